// ----- src/wptb_pkg.sv -----
// ----------------------------------------------------------------------------
// wptb_pkg
// Shared types and constants of the wrapping polyline track builder:
// register indexes, reset values, datapath step codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wptb_pkg;

    // configuration register map
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_WORLD_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WORLD_HEIGHT = 2'd1;

    localparam int          CFG_W          = 16;
    localparam logic [15:0] WORLD_W_RESET  = 16'd16384;
    localparam logic [15:0] WORLD_H_RESET  = 16'd8192;

    // word field widths
    localparam int COORD_W = 16;
    localparam int OUT_X_W = 18;
    localparam int LEN_W   = 40;

    // multiply sequence, one step per cycle on the shared multiplier
    localparam int MUL_STEPS = 8;
    localparam int MSTEP_W   = 3;
    localparam logic [MSTEP_W-1:0] MS_OX    = 3'd0; // prev x * width
    localparam logic [MSTEP_W-1:0] MS_PX    = 3'd1; // new x * width
    localparam logic [MSTEP_W-1:0] MS_OY    = 3'd2; // prev y * height
    localparam logic [MSTEP_W-1:0] MS_PY    = 3'd3; // new y * height, dx ready
    localparam logic [MSTEP_W-1:0] MS_HOLD  = 3'd4; // round last y product
    localparam logic [MSTEP_W-1:0] MS_SQ_DX = 3'd5; // dx squared, dy ready
    localparam logic [MSTEP_W-1:0] MS_SQ_DY = 3'd6; // dy squared
    localparam logic [MSTEP_W-1:0] MS_SUM   = 3'd7; // add squares

    // emit slots within one input
    localparam int SEL_W = 2;
    localparam logic [SEL_W-1:0] SEL_CLOSE = 2'd0; // wrapped copy of new point
    localparam logic [SEL_W-1:0] SEL_OPEN  = 2'd1; // wrapped copy of prev point
    localparam logic [SEL_W-1:0] SEL_POINT = 2'd2; // the point itself

    typedef struct packed {
        logic               load_in;
        logic               mul_en;
        logic [MSTEP_W-1:0] mul_step;
        logic               root_init;
        logic               root_step;
        logic               acc;
        logic               emit_load;
        logic [SEL_W-1:0]   emit_sel;
        logic               commit;
    } t_cmd;

    typedef struct packed {
        logic first;    // no point seen yet
        logic same;     // new point equals previous
        logic wrap;     // seam crossing in x
        logic out_free; // output register can take a word
    } t_sts;

endpackage

// ----- src/wptb_ctrl.sv -----
// ----------------------------------------------------------------------------
// wptb_ctrl
// Sequencer of the track builder: accepts one point at a time, walks the
// datapath through the multiply steps, the root iterations, the length
// update and the emission of up to three words.
// ----------------------------------------------------------------------------
module wptb_ctrl #(
    parameter int ROOT_STEPS = 26
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  wptb_pkg::t_sts  i_sts,
    output wptb_pkg::t_cmd  o_cmd
);
    import wptb_pkg::*;

    localparam int CNT_W = (ROOT_STEPS > MUL_STEPS) ? $clog2(ROOT_STEPS) : $clog2(MUL_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_RINIT = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SEL_W-1:0] w_last_sel;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_last_sel = i_sts.wrap ? SEL_POINT : SEL_CLOSE;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_step = r_cnt[MSTEP_W-1:0];
        o_cmd.emit_sel = r_cnt[SEL_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt         = '0;
                    n_state       = i_sts.first ? S_EMIT : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_RINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RINIT: begin
                o_cmd.root_init = 1'b1;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.same) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (r_cnt[SEL_W-1:0] == w_last_sel) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- src/wptb_datapath.sv -----
// ----------------------------------------------------------------------------
// wptb_datapath
// Point registers, world size registers, shared multiplier, bit-serial
// square root, saturating length accumulator and the output word register.
// ----------------------------------------------------------------------------
module wptb_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  wptb_pkg::t_cmd                        i_cmd,
    output wptb_pkg::t_sts                        o_sts,
    input  logic [wptb_pkg::COORD_W-1:0]          i_point_x,
    input  logic [wptb_pkg::COORD_W-1:0]          i_point_y,
    input  logic                                  i_cfg_we,
    input  logic [wptb_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [wptb_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [wptb_pkg::OUT_X_W-1:0]   o_out_x,
    output logic [wptb_pkg::COORD_W-1:0]          o_out_y,
    output logic                                  o_starts_line,
    output logic [wptb_pkg::LEN_W-1:0]            o_path_length,
    output logic                                  o_last
);
    import wptb_pkg::*;

    // world coordinate, multiplier, radicand and root widths
    localparam int WC_W  = 33 - FRAC_BITS;
    localparam int MUL_W = (WC_W > COORD_W) ? WC_W : COORD_W;
    localparam int SUM_W = 2 * WC_W + 1;
    localparam int RT_W  = WC_W + 9;
    localparam int RAD_W = 2 * RT_W;

    localparam logic [63:0] HALF_W = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] ONE_W  = 64'd1 << FRAC_BITS;
    localparam logic [OUT_X_W-1:0] ONE_X = ONE_W[OUT_X_W-1:0];

    logic [COORD_W-1:0]   r_ww, r_wh;
    logic                 r_have_prev;
    logic [COORD_W-1:0]   r_ox, r_oy, r_px, r_py;
    logic [2*MUL_W-1:0]   r_prod;
    logic [WC_W-1:0]      r_wa, r_wb, r_dx, r_dy;
    logic [SUM_W-1:0]     r_sum;
    logic [RAD_W-1:0]     r_rad;
    logic [RT_W+1:0]      r_rem;
    logic [RT_W-1:0]      r_root;
    logic [LEN_W-1:0]     r_len;
    logic                 r_out_valid;
    logic [OUT_X_W-1:0]   r_out_x;
    logic [COORD_W-1:0]   r_out_y;
    logic [LEN_W-1:0]     r_out_len;
    logic                 r_starts, r_last;

    logic [MUL_W-1:0]     w_ma, w_mb;
    logic [32:0]          w_rsum;
    logic [WC_W-1:0]      w_rnd, w_absd;
    logic [RT_W+1:0]      w_rem_sh, w_trial;
    logic                 w_ge;
    logic [LEN_W:0]       w_lsum;
    logic [COORD_W:0]     w_dpos, w_dneg;
    logic                 w_wrap_pos, w_wrap_neg, w_wrap;
    logic [OUT_X_W-1:0]   w_px18, w_ox18, w_x_sel;
    logic [COORD_W-1:0]   w_y_sel;

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.mul_step)
            MS_OX: begin
                w_ma = MUL_W'(r_ox);
                w_mb = MUL_W'(r_ww);
            end
            MS_PX: begin
                w_ma = MUL_W'(r_px);
                w_mb = MUL_W'(r_ww);
            end
            MS_OY: begin
                w_ma = MUL_W'(r_oy);
                w_mb = MUL_W'(r_wh);
            end
            MS_PY: begin
                w_ma = MUL_W'(r_py);
                w_mb = MUL_W'(r_wh);
            end
            MS_SQ_DX: begin
                w_ma = MUL_W'(r_dx);
                w_mb = MUL_W'(r_dx);
            end
            MS_SQ_DY: begin
                w_ma = MUL_W'(r_dy);
                w_mb = MUL_W'(r_dy);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // round half up to world units, distance on one axis
    assign w_rsum = {1'b0, r_prod[31:0]} + HALF_W[32:0];
    assign w_rnd  = w_rsum[32:FRAC_BITS];
    assign w_absd = (r_wa >= r_wb) ? (r_wa - r_wb) : (r_wb - r_wa);

    // one root digit per cycle
    assign w_rem_sh = {r_rem[RT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    // saturating length add
    assign w_lsum = {1'b0, r_len} + (LEN_W + 1)'(r_root);

    // seam detection on raw x
    assign w_dpos     = {1'b0, r_px} - {1'b0, r_ox};
    assign w_dneg     = {1'b0, r_ox} - {1'b0, r_px};
    assign w_wrap_pos = !w_dpos[COORD_W] && ({48'd0, w_dpos[COORD_W-1:0]} >= HALF_W);
    assign w_wrap_neg = !w_dneg[COORD_W] && ({48'd0, w_dneg[COORD_W-1:0]} >= HALF_W);
    assign w_wrap     = r_have_prev && (w_wrap_pos || w_wrap_neg);

    assign o_sts.first    = !r_have_prev;
    assign o_sts.same     = (r_px == r_ox) && (r_py == r_oy);
    assign o_sts.wrap     = w_wrap;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // vertex select for the current emit slot
    assign w_px18 = OUT_X_W'(r_px);
    assign w_ox18 = OUT_X_W'(r_ox);
    always_comb begin
        w_x_sel = w_px18;
        w_y_sel = r_py;
        if (w_wrap) begin
            case (i_cmd.emit_sel)
                SEL_CLOSE: begin
                    w_x_sel = w_wrap_pos ? (w_px18 - ONE_X) : (w_px18 + ONE_X);
                end
                SEL_OPEN: begin
                    w_x_sel = w_wrap_pos ? (w_ox18 + ONE_X) : (w_ox18 - ONE_X);
                    w_y_sel = r_oy;
                end
                default: begin
                    w_x_sel = w_px18;
                end
            endcase
        end
    end

    // configuration and track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ww        <= WORLD_W_RESET;
            r_wh        <= WORLD_H_RESET;
            r_have_prev <= 1'b0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_len       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WORLD_WIDTH:  r_ww <= i_cfg_data;
                    REG_WORLD_HEIGHT: r_wh <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.acc) begin
                r_len <= w_lsum[LEN_W] ? '1 : w_lsum[LEN_W-1:0];
            end
            if (i_cmd.commit) begin
                r_have_prev <= 1'b1;
                r_ox        <= r_px;
                r_oy        <= r_py;
            end
        end
    end

    // input capture, multiply sequence and root
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
            unique case (i_cmd.mul_step)
                MS_PX:    r_wa <= w_rnd;
                MS_OY:    r_wb <= w_rnd;
                MS_PY: begin
                    r_dx <= w_absd;
                    r_wa <= w_rnd;
                end
                MS_HOLD:  r_wb <= w_rnd;
                MS_SQ_DX: r_dy <= w_absd;
                MS_SQ_DY: r_sum <= SUM_W'(r_prod[2*WC_W-1:0]);
                MS_SUM:   r_sum <= r_sum + SUM_W'(r_prod[2*WC_W-1:0]);
                default: ;
            endcase
        end
        if (i_cmd.root_init) begin
            r_rad  <= RAD_W'({r_sum, 16'd0});
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_ge) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[RT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[RT_W-2:0], 1'b0};
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_x   <= w_x_sel;
            r_out_y   <= w_y_sel;
            r_out_len <= r_len;
            r_starts  <= !r_have_prev || (w_wrap && (i_cmd.emit_sel == SEL_OPEN));
            r_last    <= !w_wrap || (i_cmd.emit_sel == SEL_POINT);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_x       = $signed(r_out_x);
    assign o_out_y       = r_out_y;
    assign o_starts_line = r_starts;
    assign o_path_length = r_out_len;
    assign o_last        = r_last;

endmodule

// ----- src/wrapping_polyline_track_builder_top.sv -----
// ----------------------------------------------------------------------------
// wrapping_polyline_track_builder_top
// Builds seam-split polylines and a running path length from a stream of
// normalized track points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_point_x, i_point_y.
//   Output channel: o_out_valid / i_out_stall with o_out_x, o_out_y,
//   o_starts_line, o_path_length, o_last; one to three words per point,
//   o_last marks the final one. A point equal to the previous gives none.
//   World sizes are written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle.
//   Points are taken one at a time. The first point ever goes straight
//   to emission. Any later point runs the multiply steps on the shared
//   multiplier, a root init, then 42 - FRAC_BITS root steps (26 at the
//   default), one length update, then the emission of its words, each
//   loaded when the output register is free. The bit-serial square root
//   is the longest of these steps at the default FRAC_BITS.
//   A stalled receiver holds the output word; the block waits with further
//   words and takes no new point until the last word of this point has
//   been loaded into the output register.
//   Reset clears the previous point, the length and the output valid, and
//   sets the world size to 16384 by 8192.
// ----------------------------------------------------------------------------
module wrapping_polyline_track_builder_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [wptb_pkg::COORD_W-1:0]          i_point_x,
    input  logic [wptb_pkg::COORD_W-1:0]          i_point_y,
    input  logic                                  i_cfg_we,
    input  logic [wptb_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [wptb_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [wptb_pkg::OUT_X_W-1:0]   o_out_x,
    output logic [wptb_pkg::COORD_W-1:0]          o_out_y,
    output logic                                  o_starts_line,
    output logic [wptb_pkg::LEN_W-1:0]            o_path_length,
    output logic                                  o_last
);
    import wptb_pkg::*;

    localparam int ROOT_STEPS = 42 - FRAC_BITS;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    wptb_ctrl #(
        .ROOT_STEPS (ROOT_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    wptb_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_starts_line (o_starts_line),
        .o_path_length (o_path_length),
        .o_last        (o_last)
    );

endmodule
